/* hw/rtl/crcrft_pkg.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger package
// Shared item types, register indexes and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package crcrft_pkg;

  localparam logic [31:0] CRC_POLY          = 32'h04C1_1DB7;
  localparam logic [31:0] MATCH_VALUE_RESET = 32'h294C_EE63;
  localparam logic [31:0] MATCH_MASK_RESET  = 32'h0000_00FF;
  localparam logic [31:0] RUN_COUNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] RUN_COUNT_FIRST   = 32'h0000_0001;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_VALUE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MASK  = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SEED  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [63:0] alloc_size;
  } in_item_t;

  typedef struct packed {
    logic        fail;
    logic [31:0] crc_value;
  } out_item_t;

  typedef struct packed {
    logic [31:0] match_value;
    logic [31:0] match_mask;
  } match_cfg_t;

  // Fold one byte into a non-reflected CRC-32, MSB first.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {data, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (crc[31]) begin
        crc = {crc[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[30:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/crcrft_cfg_regs.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger configuration registers
// Holds the match value and match mask; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module crcrft_cfg_regs
  import crcrft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output match_cfg_t             match_cfg
);

  match_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign match_cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.match_value <= MATCH_VALUE_RESET;
      regs.match_mask  <= MATCH_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MATCH_VALUE) begin
        regs.match_value <= cfg_data;
      end else if (cfg_index == REG_MATCH_MASK) begin
        regs.match_mask <= cfg_data;
      end
    end
  end

endmodule

/* hw/rtl/crcrft_in_stage.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger input register
// Captures one input transfer and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module crcrft_in_stage
  import crcrft_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     take,
  output logic     held_valid,
  output in_item_t held_item
);

  logic load;

  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= load || (held_valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_hold_untaken: assert property (@(posedge clk) disable iff (rst)
    held_valid && !take |=> held_valid && $stable(held_item))
    else $error("input register lost or changed an untaken item");
`endif

endmodule

/* hw/rtl/crcrft_engine.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger engine
// Updates CRC, run count and active flag per item and loads the result register.
// ----------------------------------------------------------------------------
module crcrft_engine
  import crcrft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       held_valid,
  input  in_item_t   held_item,
  output logic       take,
  input  match_cfg_t match_cfg,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [31:0] crc;
  logic [31:0] run_count;
  logic        active;

  logic [31:0] crc_next;
  logic [31:0] run_count_next;
  logic        active_next;
  logic        fail_next;

  logic [31:0] crc_b0;
  logic [31:0] crc_b1;
  logic [31:0] crc_b2;
  logic        size_hi1;
  logic        size_hi2;

  assign take = held_valid && (!out_valid || !out_stall);

  assign size_hi1 = |held_item.alloc_size[63:8];
  assign size_hi2 = |held_item.alloc_size[63:16];

  always_comb begin
    crc_b0 = fold_byte(crc, held_item.alloc_size[7:0]);
    crc_b1 = size_hi1 ? fold_byte(crc_b0, held_item.alloc_size[15:8]) : crc_b0;
    crc_b2 = size_hi2 ? fold_byte(crc_b1, held_item.alloc_size[23:16]) : crc_b1;
  end

  always_comb begin
    crc_next       = crc;
    run_count_next = run_count;
    active_next    = active;
    fail_next      = 1'b0;
    case (held_item.op)
      OP_START: begin
        crc_next    = '0;
        active_next = 1'b1;
        if (run_count != RUN_COUNT_MAX) begin
          run_count_next = run_count + 32'd1;
        end
      end
      OP_SEED: begin
        crc_next = fold_byte(crc, held_item.data_byte);
      end
      OP_ALLOC: begin
        if (active) begin
          crc_next  = crc_b2;
          fail_next = (((crc_b2 ^ match_cfg.match_value) & match_cfg.match_mask) == '0)
                      && (run_count != RUN_COUNT_FIRST);
        end
      end
      OP_END: begin
        active_next = 1'b0;
      end
      default: begin
        active_next = active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= '0;
      run_count <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        crc       <= crc_next;
        run_count <= run_count_next;
        active    <= active_next;
      end
      out_valid <= take || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.fail      <= fail_next;
      out_item.crc_value <= crc_next;
    end
  end

`ifndef SYNTHESIS
  a_crc_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.crc_value == crc)
    else $error("result CRC differs from CRC register");

  a_fail_needs_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fail |-> active && run_count != RUN_COUNT_FIRST)
    else $error("failure flagged while inactive or in first run");

  a_take_loads_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken item did not reach the result register");
`endif

endmodule

/* hw/rtl/crc_random_fault_trigger_top.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger
// Pseudo-random allocation failure decision from a running CRC-32 register.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in       | into      | in_valid / in_stall  | in_item  (op, data_byte, size)
//   out      | out of    | out_valid / out_stall| out_item (fail, crc_value)
//   cfg      | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each transfer is held in
// the input register until the engine takes it, then the CRC fold (up to three
// bytes) and fail test run into the result register, which holds the result
// until it transfers.
// Reset (rst, synchronous) clears the CRC, run count, active flag and both
// valid bits, and loads the match registers with their default values.
// A stalled result keeps the input register full; a new transfer is still taken
// while the input register is empty or moving on. Configuration writes are
// always ready; indexes other than match value and match mask are dropped.
//
module crc_random_fault_trigger_top
  import crcrft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  match_cfg_t match_cfg;
  logic       held_valid;
  in_item_t   held_item;
  logic       take;

  // Match value and mask registers.
  crcrft_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .match_cfg (match_cfg)
  );

  // Input register: hold the transfer until the engine takes it.
  crcrft_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Advance the CRC state and load the result register.
  crcrft_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .match_cfg  (match_cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

/* tb/sv/crc_random_fault_trigger_top_tb.sv */
// ----------------------------------------------------------------------------
// CRC random fault trigger testbench
// Drives start, seed, allocation and end-run items with random idle and stall
// patterns, recomputes each fail decision and CRC value in a local predictor
// and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module crc_random_fault_trigger_top_tb;
  import crcrft_pkg::*;

  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 11;
  localparam int SETTLE_CYCLES    = 6;        // pipeline is two deep; leave margin
  localparam int TIMEOUT_CYCLES   = 400_000;
  localparam int PHASE_ITEMS      = 172;
  localparam int LONG_HOLD_AT     = 430;      // results seen before the long hold
  localparam int LONG_HOLD_CYCLES = 150;

  localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BYTE1_FROM  = 64'h0000_0000_0000_0100;
  localparam logic [63:0] BYTE2_FROM  = 64'h0000_0000_0001_0000;

  // Indexes past the two match registers; the block drops writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  // One row of the directed script: either a register write (index in
  // reg_index, data in the low word of alloc_size) or an input item, with an
  // optional hand-written expectation.
  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    op_t                    op;
    logic [7:0]             data_byte;
    logic [63:0]            alloc_size;
    logic                   known;
    logic                   fail;
    logic [31:0]            crc;
  } script_row_t;

  localparam int NUM_ROWS = 25;
  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    // inactive after reset: end run and allocation change nothing
    '{1'b0, REG_MATCH_VALUE, OP_END,   8'h00, 64'h0,        1'b1, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'hFF, ALL_ONES_64,  1'b1, 1'b0, 32'h0},
    // seed folds even while inactive; a lone 0x01 byte leaves the polynomial
    '{1'b0, REG_MATCH_VALUE, OP_SEED,  8'h01, ALL_ONES_64,  1'b1, 1'b0, 32'h04C1_1DB7},
    '{1'b0, REG_MATCH_VALUE, OP_SEED,  8'hFF, 64'h0,        1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'h1234,     1'b0, 1'b0, 32'h0},
    // first run opens with a cleared register
    '{1'b0, REG_MATCH_VALUE, OP_START, 8'hFF, ALL_ONES_64,  1'b1, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h5A, 64'h0,        1'b1, 1'b0, 32'h0},
    // size boundaries for one, two and three folded bytes
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'hFF,       1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'h100,      1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'hFFFF,     1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'h1_0000,   1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'hFF_FFFF,  1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'h0123_4567_89AB_CDEF,
      1'b0, 1'b0, 32'h0},
    // empty mask: every active request matches from here on
    '{1'b1, REG_MATCH_MASK,  OP_START, 8'h00, 64'h0,        1'b0, 1'b0, 32'h0},
    // still the first run, so no failure despite the match
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, ALL_ONES_64,  1'b0, 1'b0, 32'h0},
    // start while active: second run
    '{1'b0, REG_MATCH_VALUE, OP_START, 8'h00, 64'h0,        1'b1, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'hC3, 64'h0,        1'b1, 1'b1, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_SEED,  8'h80, 64'h5555_5555_5555_5555,
      1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'h55,       1'b0, 1'b0, 32'h0},
    // end run keeps the register; a second end does nothing
    '{1'b0, REG_MATCH_VALUE, OP_END,   8'hA5, ALL_ONES_64,  1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_END,   8'h00, 64'h0,        1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_SEED,  8'hA5, 64'h0,        1'b0, 1'b0, 32'h0},
    '{1'b0, REG_MATCH_VALUE, OP_ALLOC, 8'h00, 64'hFF00,     1'b0, 1'b0, 32'h0},
    // writes past the last register are dropped
    '{1'b1, REG_SPARE_A,     OP_START, 8'h00, 64'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b1, REG_SPARE_B,     OP_START, 8'h00, 64'hFFFF_FFFF, 1'b0, 1'b0, 32'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  // Predictor state: the trigger's own copy of CRC, run tally and settings.
  logic [31:0] trig_crc;
  logic [31:0] run_tally;
  logic        run_open;
  logic [31:0] cur_value;
  logic [31:0] cur_mask;

  out_item_t pending_decisions [$];
  out_item_t want_res;

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fails_seen   = 0;
  int unsigned reg_writes   = 0;
  int unsigned phases_run   = 0;
  logic        burst_mode   = 1'b0;

  // Result-side stall pacing, owned by the sink process.
  int unsigned sink_hold_left = 0;
  int unsigned sink_free_left = 0;
  logic        sink_long_done = 1'b0;

  crc_random_fault_trigger_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shift one byte through the CRC, one message bit at a time, MSB first.
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] acc,
                                                 input logic [7:0]  msg);
    logic [31:0] x;
    logic        feedback;
    x = acc;
    for (int i = 7; i >= 0; i--) begin
      feedback = x[31] ^ msg[i];
      x = x << 1;
      if (feedback) begin
        x = x ^ CRC_POLY;
      end
    end
    return x;
  endfunction

  // Advance the predictor by one item and return the decision it implies.
  function automatic out_item_t decide_item(input in_item_t it);
    out_item_t r;
    r.fail = 1'b0;
    case (it.op)
      OP_START: begin
        trig_crc = '0;
        if (run_tally != RUN_COUNT_MAX) begin
          run_tally = run_tally + 1;
        end
        run_open = 1'b1;
      end
      OP_SEED: begin
        trig_crc = crc_shift_byte(trig_crc, it.data_byte);
      end
      OP_ALLOC: begin
        if (run_open) begin
          trig_crc = crc_shift_byte(trig_crc, it.alloc_size[7:0]);
          if (it.alloc_size >= BYTE1_FROM) begin
            trig_crc = crc_shift_byte(trig_crc, it.alloc_size[15:8]);
          end
          if (it.alloc_size >= BYTE2_FROM) begin
            trig_crc = crc_shift_byte(trig_crc, it.alloc_size[23:16]);
          end
          r.fail = (((trig_crc ^ cur_value) & cur_mask) == 32'h0) &&
                   (run_tally != RUN_COUNT_FIRST);
        end
      end
      OP_END: begin
        run_open = 1'b0;
      end
      default: ;
    endcase
    r.crc_value = trig_crc;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 2);
    end else if (roll < 96) begin
      return $urandom_range(3, 8);
    end else begin
      return $urandom_range(15, 40);
    end
  endfunction

  // Allocation sizes spread over one, two, three and full-width values, plus the byte boundaries.
  function automatic logic [63:0] pick_size();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 255));
      1: return 64'($urandom_range(0, 16'hFFFF));
      2: return 64'($urandom_range(0, 24'hFF_FFFF));
      3: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 3))
          0: return BYTE1_FROM - 1;
          1: return BYTE1_FROM;
          2: return BYTE2_FROM - 1;
          default: return BYTE2_FROM;
        endcase
      end
    endcase
  endfunction

  // Random content for one item; unused fields carry noise too.
  function automatic in_item_t make_item(input op_t op);
    in_item_t it;
    it.op         = op;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.alloc_size = (op == OP_ALLOC) ? pick_size() : {$urandom, $urandom};
    return it;
  endfunction

  // Offer one item, hold it until the transfer, record the expected
  // decision, then idle for a random gap unless a burst is running.
  task automatic send_item(input in_item_t it, input logic typed,
                           input out_item_t typed_res);
    out_item_t guess;
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    guess = decide_item(it);
    pending_decisions.push_back(typed ? typed_res : guess);
    items_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, let every expected result drain, then settle the pipeline.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MATCH_VALUE: cur_value = val;
      REG_MATCH_MASK:  cur_mask  = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One run as software would issue it: start, seeds, allocations with an
  // occasional extra seed, and usually an end.
  task automatic play_run();
    int unsigned seeds;
    int unsigned allocs;
    send_item(make_item(OP_START), 1'b0, '0);
    seeds = $urandom_range(0, 6);
    repeat (seeds) send_item(make_item(OP_SEED), 1'b0, '0);
    allocs = $urandom_range(1, 12);
    repeat (allocs) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(make_item(OP_SEED), 1'b0, '0);
      end else begin
        send_item(make_item(OP_ALLOC), 1'b0, '0);
      end
    end
    if ($urandom_range(0, 9) < 8) begin
      send_item(make_item(OP_END), 1'b0, '0);
    end
  endtask

  // Result sink: alternate free and stalled stretches, and once hold off
  // for a long stretch so the pipeline backs up into the input.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_hold_left != 0) begin
      out_stall <= 1'b1;
      sink_hold_left = sink_hold_left - 1;
    end else if (!sink_long_done && results_seen >= LONG_HOLD_AT) begin
      sink_long_done = 1'b1;
      sink_hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (sink_free_left != 0) begin
      out_stall <= 1'b0;
      sink_free_left = sink_free_left - 1;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: sink_free_left = $urandom_range(0, 3);
        6, 7, 8:          sink_free_left = $urandom_range(4, 15);
        default:          sink_free_left = $urandom_range(30, 80);
      endcase
      sink_hold_left = pick_gap();
    end
  end

  // Check each result transfer against the oldest pending decision.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_item.fail) begin
        fails_seen++;
      end
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result fail=%0b crc=%08h", $time,
                 out_item.fail, out_item.crc_value);
        errors++;
      end else begin
        want_res = pending_decisions.pop_front();
        if (out_item.fail !== want_res.fail) begin
          $display("%0t: fail mismatch: expected %0b actual %0b", $time,
                   want_res.fail, out_item.fail);
          errors++;
        end
        if (out_item.crc_value !== want_res.crc_value) begin
          $display("%0t: crc mismatch: expected %08h actual %08h", $time,
                   want_res.crc_value, out_item.crc_value);
          errors++;
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results outstanding", $time,
             pending_decisions.size());
    $display("crc_random_fault_trigger_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    script_row_t row;
    in_item_t    stim;
    out_item_t   typed;
    int unsigned phase_start;
    logic [31:0] phase_value;
    logic [31:0] phase_mask;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Start the predictor from the reset state.
    trig_crc  = '0;
    run_tally = '0;
    run_open  = 1'b0;
    cur_value = MATCH_VALUE_RESET;
    cur_mask  = MATCH_MASK_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed script; register writes wait for an idle block.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.is_write) begin
        quiesce();
        write_reg(row.reg_index, row.alloc_size[31:0]);
      end else begin
        stim.op          = row.op;
        stim.data_byte   = row.data_byte;
        stim.alloc_size  = row.alloc_size;
        typed.fail       = row.fail;
        typed.crc_value  = row.crc;
        send_item(stim, row.known, typed);
      end
    end

    // Random phases, each under its own match setting: both extremes of the
    // mask, both extremes of the value, narrow masks that fire often and a
    // fully random pair.
    for (int p = 0; p < 6; p++) begin
      quiesce();
      phase_value = $urandom;
      case (p)
        0: begin phase_value = 32'h0;         phase_mask = 32'hFFFF_FFFF; end
        1: begin phase_value = 32'hFFFF_FFFF; phase_mask = 32'hFFFF_FFFF; end
        2: phase_mask = 32'h0000_0003;
        3: phase_mask = $urandom & $urandom & $urandom;
        4: phase_mask = 32'h0;
        default: phase_mask = $urandom;
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_MATCH_VALUE, phase_value);
        write_reg(REG_MATCH_MASK, phase_mask);
      end else begin
        write_reg(REG_MATCH_MASK, phase_mask);
        write_reg(REG_MATCH_VALUE, phase_value);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      end
      phases_run++;

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // Now and then run a whole sequence back to back.
        burst_mode = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 85) begin
          play_run();
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(make_item(op_t'($urandom_range(0, 3))), 1'b0, '0);
          end
        end
      end
      burst_mode = 1'b0;
    end

    // Drain, then watch a little longer for stray results.
    quiesce();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items over %0d random match settings, %0d register writes",
             items_sent, phases_run, reg_writes);
    $display("checked %0d results, %0d of them failed requests, %0d runs started",
             results_seen, fails_seen, run_tally);
    if (errors == 0) begin
      $display("crc_random_fault_trigger_top_tb: clean");
    end else begin
      $display("crc_random_fault_trigger_top_tb: errors");
    end
    $finish;
  end

endmodule
